[rtl/ckd_pkg.sv]
// Shared types and constants for the chord keyboard decoder.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ckd_pkg;

  // Sizing of the press history and the layout table
  localparam int HISTORY_DEPTH  = 16;
  localparam int LAYOUT_ENTRIES = 64;
  localparam int HIST_CNT_W     = $clog2(HISTORY_DEPTH + 1);
  localparam int LAYOUT_IDX_W   = 6;
  localparam int LAYOUT_CNT_W   = 7;
  localparam int FINGERS        = 4;

  // Input transaction codes
  localparam logic FUNC_SCAN  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // Finger state codes
  localparam logic [1:0] FINGER_LOW_ONLY  = 2'd2;
  localparam logic [1:0] FINGER_HIGH_ONLY = 2'd1;

  typedef struct packed {
    logic       func;
    logic [7:0] switch_state;
    logic [7:0] entry_chord;
  } ckd_in_t;

  typedef struct packed {
    logic                    chord_ready;
    logic [7:0]              chord_code;
    logic                    match_found;
    logic [LAYOUT_IDX_W-1:0] match_index;
  } ckd_out_t;

  // Status from the table search unit to the sequencer
  typedef struct packed {
    logic                    done;
    logic                    found;
    logic [LAYOUT_IDX_W-1:0] index;
  } ckd_srch_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT
  } ckd_state_t;

endpackage

`default_nettype wire

[rtl/chord_keyboard_decoder_top.sv]
// Chord keyboard decoder top level: transaction sequencer and output register.
// Depends on ckd_pkg, ckd_history and ckd_search.
`default_nettype none

// Every input transaction yields exactly one result transaction. A layout write
// or a scan that finishes no chord passes through ST_EMIT into the output
// register. A release that ends a press first goes through ST_SEARCH, which
// searches the loaded layout table one entry per cycle through a single memory
// read port and comparator and stops at the first matching entry or after the
// last loaded entry; its result then passes through ST_EMIT into the output
// register. The input is stalled from acceptance until the result has been
// moved into the output register; the output register may still be waiting on
// a stalled consumer when the next transaction is accepted, and a result stuck
// behind it waits in ST_EMIT until the consumer takes the old one.
module chord_keyboard_decoder_top
  import ckd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire ckd_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output ckd_out_t      out_data
);

  ckd_state_t     state_r, state_nxt;
  ckd_out_t       res_r, res_nxt;
  ckd_out_t       out_data_r, out_data_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           accept;
  logic           is_scan;
  logic           is_write;
  logic           chord_done;
  logic           srch_start;
  logic           out_free;
  logic [7:0]     first_snapshot;
  logic           hist_nonempty;
  ckd_srch_stat_t srch_stat;

  assign in_stall   = (state_r != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign is_scan    = (in_data.func == FUNC_SCAN);
  assign is_write   = (in_data.func == FUNC_WRITE);
  assign chord_done = is_scan && (in_data.switch_state == 8'd0) && hist_nonempty;
  assign out_free   = !out_valid_r || !out_stall;

  ckd_history u_history (
    .clk            (clk),
    .rst_n          (rst_n),
    .upd            (accept && is_scan),
    .sw             (in_data.switch_state),
    .first_snapshot (first_snapshot),
    .hist_nonempty  (hist_nonempty)
  );

  ckd_search u_search (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (accept && is_write),
    .wr_chord (in_data.entry_chord),
    .start    (srch_start),
    .code     (first_snapshot),
    .stat     (srch_stat)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = chord_done ? ST_SEARCH : ST_EMIT;
        end
      end
      ST_SEARCH: begin
        if (srch_stat.done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: result assembly, search start, output register load
  always_comb begin
    res_nxt       = res_r;
    srch_start    = 1'b0;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_nxt = '0;
          if (chord_done) begin
            res_nxt.chord_ready = 1'b1;
            res_nxt.chord_code  = first_snapshot;
            srch_start          = 1'b1;
          end
        end
      end
      ST_SEARCH: begin
        if (srch_stat.done) begin
          res_nxt.match_found = srch_stat.found;
          res_nxt.match_index = srch_stat.index;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
        end
      end
      default: begin
        res_nxt = res_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[rtl/ckd_history.sv]
// Press history tracker: first/last snapshot and snapshot count of the current press.
// Depends on ckd_pkg.
`default_nettype none

module ckd_history
  import ckd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       upd,
  input  wire logic [7:0] sw,
  output logic [7:0]      first_snapshot,
  output logic            hist_nonempty
);

  logic [7:0]            first_r, first_nxt;
  logic [7:0]            last_r, last_nxt;
  logic [HIST_CNT_W-1:0] cnt_r, cnt_nxt;

  // A finger rising, or going from low-only to high-only, starts a new press
  function automatic logic press_starts(input logic [7:0] prev, input logic [7:0] next);
    logic       hit;
    logic [1:0] a;
    logic [1:0] b;
    hit = 1'b0;
    for (int f = 0; f < FINGERS; f++) begin
      a = prev[2*f +: 2];
      b = next[2*f +: 2];
      if (b > a || (a == FINGER_LOW_ONLY && b == FINGER_HIGH_ONLY)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  // History update for one accepted scan
  always_comb begin
    first_nxt = first_r;
    last_nxt  = last_r;
    cnt_nxt   = cnt_r;
    if (upd) begin
      // overflow: keep only the first snapshot
      if (cnt_r >= HIST_CNT_W'(HISTORY_DEPTH)) begin
        cnt_nxt  = HIST_CNT_W'(1);
        last_nxt = first_r;
      end
      if (sw == 8'd0) begin
        cnt_nxt = '0;
      end else begin
        if (cnt_nxt != '0 && press_starts(last_nxt, sw)) begin
          cnt_nxt = '0;
        end
        if (cnt_nxt == '0) begin
          first_nxt = sw;
        end
        last_nxt = sw;
        cnt_nxt  = cnt_nxt + HIST_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
      last_r  <= '0;
      cnt_r   <= '0;
    end else begin
      first_r <= first_nxt;
      last_r  <= last_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign first_snapshot = first_r;
  assign hist_nonempty  = (cnt_r != '0);

endmodule

`default_nettype wire

[rtl/ckd_search.sv]
// Layout table memory with a shared compare unit that scans loaded entries one per cycle.
// Depends on ckd_pkg.
`default_nettype none

module ckd_search
  import ckd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       wr_en,
  input  wire logic [7:0] wr_chord,
  input  wire logic       start,
  input  wire logic [7:0] code,
  output ckd_srch_stat_t  stat
);

  logic [7:0] mem [LAYOUT_ENTRIES];

  logic [LAYOUT_CNT_W-1:0] count_r, count_nxt;
  logic                    busy_r, busy_nxt;
  logic [LAYOUT_CNT_W-1:0] addr_r, addr_nxt;
  logic                    cmp_vld_r, cmp_vld_nxt;
  logic [LAYOUT_IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [7:0]              code_r, code_nxt;
  logic [7:0]              rd_data_r;
  logic                    issue;
  logic                    hit;
  logic                    done;
  logic                    do_wr;

  // Append only while the table has room
  assign do_wr = wr_en && (count_r < LAYOUT_CNT_W'(LAYOUT_ENTRIES));
  assign issue = busy_r && (addr_r < count_r);
  assign hit   = cmp_vld_r && (rd_data_r == code_r);
  assign done  = busy_r && (hit || (!issue && !cmp_vld_r));

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[count_r[LAYOUT_IDX_W-1:0]] <= wr_chord;
    end
    if (issue) begin
      rd_data_r <= mem[addr_r[LAYOUT_IDX_W-1:0]];
    end
  end

  // Scan sequencing: read address stage then compare stage
  always_comb begin
    count_nxt   = count_r;
    busy_nxt    = busy_r;
    addr_nxt    = addr_r;
    cmp_vld_nxt = 1'b0;
    cmp_idx_nxt = cmp_idx_r;
    code_nxt    = code_r;
    if (do_wr) begin
      count_nxt = count_r + LAYOUT_CNT_W'(1);
    end
    if (start) begin
      busy_nxt = 1'b1;
      addr_nxt = '0;
      code_nxt = code;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (issue) begin
      cmp_vld_nxt = 1'b1;
      cmp_idx_nxt = addr_r[LAYOUT_IDX_W-1:0];
      addr_nxt    = addr_r + LAYOUT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      busy_r    <= 1'b0;
      addr_r    <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      busy_r    <= busy_nxt;
      addr_r    <= addr_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cmp_idx_nxt;
    code_r    <= code_nxt;
  end

  assign stat.done  = done;
  assign stat.found = hit;
  assign stat.index = hit ? cmp_idx_r : '0;

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Testbench for chord_keyboard_decoder_top: drives scan and layout-write transactions,
// predicts each result with its own chord tracker and checks every result in order.
// Depends on ckd_pkg and the decoder RTL.
`default_nettype none

module tb_top;
  import ckd_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 100;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  ckd_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ckd_out_t out_data;

  // Chord tracker state, kept in step with accepted input transactions
  logic [7:0] chord_first;
  logic [7:0] chord_last;
  int         press_len;
  logic [7:0] layout_tab [LAYOUT_ENTRIES];
  int         layout_used;

  ckd_out_t chord_results_q [$];
  int       err_cnt     = 0;
  int       items_sent  = 0;
  int       cycle_cnt   = 0;
  bit       hold_req    = 1'b0;
  bit       hold_active = 1'b0;

  chord_keyboard_decoder_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #(CLK_HALF);
    clk = 1'b1;
    #(CLK_HALF);
  end

  // A finger rising, or going from low-only to high-only, starts a new press
  function automatic bit is_new_press(logic [7:0] prev, logic [7:0] next);
    logic [1:0] a;
    logic [1:0] b;
    for (int f = 0; f < FINGERS; f++) begin
      a = prev[2*f +: 2];
      b = next[2*f +: 2];
      if (b > a || (a == FINGER_LOW_ONLY && b == FINGER_HIGH_ONLY)) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Update the tracker with one transaction and return the result it should produce
  function automatic ckd_out_t decode_item(ckd_in_t item);
    ckd_out_t res;
    res = '0;
    if (item.func == FUNC_WRITE) begin
      if (layout_used < LAYOUT_ENTRIES) begin
        layout_tab[layout_used] = item.entry_chord;
        layout_used++;
      end
    end else begin
      // Result comes from the state before this scan
      if (item.switch_state == 8'h00 && press_len != 0) begin
        res.chord_ready = 1'b1;
        res.chord_code  = chord_first;
        for (int i = 0; i < layout_used; i++) begin
          if (layout_tab[i] == chord_first) begin
            res.match_found = 1'b1;
            res.match_index = LAYOUT_IDX_W'(i);
            break;
          end
        end
      end
      // History full: collapse to the first snapshot alone
      if (press_len >= HISTORY_DEPTH) begin
        press_len  = 1;
        chord_last = chord_first;
      end
      if (item.switch_state == 8'h00) begin
        press_len = 0;
      end else begin
        if (press_len != 0 && is_new_press(chord_last, item.switch_state)) press_len = 0;
        if (press_len == 0) chord_first = item.switch_state;
        chord_last = item.switch_state;
        press_len++;
      end
    end
    return res;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int next_gap(bit burst);
    return burst ? 0 : pick_gap();
  endfunction

  function automatic ckd_in_t scan_item(logic [7:0] sw);
    ckd_in_t item;
    item.func         = FUNC_SCAN;
    item.switch_state = sw;
    item.entry_chord  = 8'($urandom_range(0, 255));
    return item;
  endfunction

  function automatic ckd_in_t write_item(logic [7:0] code);
    ckd_in_t item;
    item.func         = FUNC_WRITE;
    item.switch_state = 8'($urandom_range(0, 255));
    item.entry_chord  = code;
    return item;
  endfunction

  // Any func and any field contents
  function automatic ckd_in_t noise_item();
    ckd_in_t item;
    item.func         = ($urandom_range(0, 1) == 0) ? FUNC_SCAN : FUNC_WRITE;
    item.switch_state = 8'($urandom_range(0, 255));
    item.entry_chord  = 8'($urandom_range(0, 255));
    return item;
  endfunction

  // Each finger stays or falls, never low-only to high-only; never all released
  function automatic logic [7:0] eased_snapshot(logic [7:0] prev);
    logic [7:0] s;
    logic [1:0] a;
    logic [1:0] b;
    s = '0;
    for (int f = 0; f < FINGERS; f++) begin
      a = prev[2*f +: 2];
      b = 2'($urandom_range(0, a));
      if (a == FINGER_LOW_ONLY && b == FINGER_HIGH_ONLY) b = a;
      s[2*f +: 2] = b;
    end
    return (s == 8'h00) ? prev : s;
  endfunction

  // Half the time a code already in the layout table, so searches hit
  function automatic logic [7:0] pick_chord();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    if (layout_used > 0 && $urandom_range(0, 1) == 1) begin
      c = layout_tab[$urandom_range(0, layout_used - 1)];
      if (c == 8'h00) c = 8'($urandom_range(1, 255));
    end
    return c;
  endfunction

  function automatic logic [7:0] absent_code();
    logic [7:0] c;
    bit         hit;
    for (int k = 1; k < 256; k++) begin
      c   = 8'(k);
      hit = 1'b0;
      for (int i = 0; i < layout_used; i++) if (layout_tab[i] == c) hit = 1'b1;
      if (!hit) return c;
    end
    return 8'h01;
  endfunction

  // Offer one transaction, wait for acceptance, record its expected result
  task automatic send_item(input ckd_in_t item, input int gap);
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    chord_results_q.push_back(decode_item(item));
    items_sent++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_scan(input logic [7:0] sw);
    send_item(scan_item(sw), pick_gap());
  endtask

  task automatic send_write(input logic [7:0] code);
    send_item(write_item(code), pick_gap());
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (chord_results_q.size() != 0) @(posedge clk);
  endtask

  // One well-formed press with random content, ending in a release
  task automatic play_press(input logic [7:0] first, input int len, input bit burst);
    logic [7:0] sw;
    sw = first;
    send_item(scan_item(sw), next_gap(burst));
    for (int k = 1; k < len; k++) begin
      case ($urandom_range(0, 19))
        0: sw = 8'($urandom_range(1, 255));
        1: begin
          send_item(write_item(8'($urandom_range(0, 255))), next_gap(burst));
          sw = eased_snapshot(sw);
        end
        default: sw = eased_snapshot(sw);
      endcase
      send_item(scan_item(sw), next_gap(burst));
    end
    send_item(scan_item(8'h00), next_gap(burst));
  endtask

  task automatic test_directed_cases();
    // release with nothing held
    send_scan(8'h00);
    // layout codes at both extremes, plus a duplicate
    send_write(8'h00);
    send_write(8'hFF);
    send_write(8'hA5);
    send_write(8'hA5);
    send_scan(8'hFF);
    send_scan(8'hFF);
    send_scan(8'h00);
    // duplicate entry: lowest index wins
    send_scan(8'hA5);
    send_scan(8'h00);
    // finger rising restarts the press; no match
    send_scan(8'h01);
    send_scan(8'h03);
    send_scan(8'h00);
    // low-only to high-only restarts the press
    send_scan(8'h02);
    send_scan(8'h01);
    send_scan(8'h00);
    // falling finger keeps the press
    send_scan(8'h0A);
    send_scan(8'h08);
    send_scan(8'h00);
    send_scan(8'h00);
    // layout write in the middle of a press
    send_scan(8'h55);
    send_write(8'h55);
    send_scan(8'h00);
  endtask

  // After the history fills, the next scan is compared with the first snapshot:
  // 0x40 -> 0x80 would be a rise, 0xC0 -> 0x80 is not
  task automatic test_history_overflow();
    send_scan(8'hC0);
    repeat (HISTORY_DEPTH - 1) send_scan(8'h40);
    send_scan(8'h80);
    send_scan(8'h00);
  endtask

  task automatic test_random_traffic(input int n_items);
    int start;
    int len;
    int r;
    bit burst;
    start = items_sent;
    while (items_sent - start < n_items) begin
      burst = ($urandom_range(0, 3) == 0);
      r     = $urandom_range(0, 9);
      if (r < 7) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(HISTORY_DEPTH, 2 * HISTORY_DEPTH + 2)
                                          : $urandom_range(1, 6);
        play_press(pick_chord(), len, burst);
      end else if (r == 7) begin
        send_item(write_item(pick_chord()), next_gap(burst));
      end else begin
        send_item(noise_item(), next_gap(burst));
      end
    end
  endtask

  // Receiver holds off while presses keep coming, so the input stalls
  task automatic test_output_backpressure();
    wait_results_drained();
    hold_req = 1'b1;
    while (!hold_active) @(posedge clk);
    for (int k = 0; k < 6; k++) play_press(pick_chord(), 3, 1'b1);
  endtask

  // Sender waits for every result before each press
  task automatic test_pause_until_drained();
    for (int k = 0; k < 4; k++) begin
      wait_results_drained();
      play_press(pick_chord(), $urandom_range(1, 4), 1'b1);
    end
  endtask

  task automatic test_layout_fill();
    logic [7:0] code;
    while (layout_used < LAYOUT_ENTRIES - 1) send_write(pick_chord());
    // last slot gets a unique code so the top index gets matched
    if (layout_used == LAYOUT_ENTRIES - 1) begin
      code = absent_code();
      send_write(code);
      play_press(code, 2, 1'b0);
    end
    // table full: these writes are dropped
    code = absent_code();
    send_write(code);
    send_write(8'hFF);
    play_press(code, 2, 1'b0);
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin : result_check
    ckd_out_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (chord_results_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        err_cnt++;
      end else begin
        exp_r = chord_results_q.pop_front();
        check_field("chord_ready", exp_r.chord_ready, out_data.chord_ready);
        check_field("chord_code", exp_r.chord_code, out_data.chord_code);
        check_field("match_found", exp_r.match_found, out_data.match_found);
        check_field("match_index", exp_r.match_index, out_data.match_index);
      end
    end
  end

  // Result-side stall: random bursts, quiet stretches, one long hold on request
  initial begin : out_stall_gen
    int stall_len;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_active = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req    = 1'b0;
        hold_active = 1'b0;
      end else begin
        stall_len = pick_gap();
        if (stall_len > 0) begin
          out_stall <= 1'b1;
          repeat (stall_len) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      repeat (($urandom_range(0, 15) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 8))
        @(posedge clk);
    end
  end

  // Timeout
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    chord_first = '0;
    chord_last  = '0;
    press_len   = 0;
    layout_used = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_history_overflow();
    test_random_traffic(300);
    test_output_backpressure();
    test_pause_until_drained();
    test_layout_fill();
    test_random_traffic(250);
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

`default_nettype wire
